/* hdl/cpwc_pkg.sv */
`timescale 1ns / 1ps

package cpwc_pkg;

    localparam int MAX_PULSES_DEF = 255;
    localparam int TIME_BITS_DEF  = 16;

    localparam int CFG_W        = 16;
    localparam int CFG_IDX_W    = 3;
    localparam int AMOUNT_W     = 24;
    localparam int PENDING_W    = 8;
    localparam int IN_TDATA_W   = 8;
    localparam int OUT_TDATA_W  = 40;

    localparam logic [CFG_W-1:0] PULSE_VALUE_RST = 16'd1;
    localparam logic [CFG_W-1:0] MIN_TICKS_RST   = 16'd20;
    localparam logic [CFG_W-1:0] MAX_TICKS_RST   = 16'd200;
    localparam logic [CFG_W-1:0] TIMEOUT_RST     = 16'd500;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLED     = 3'd0,
        CFG_PULSE_VALUE = 3'd1,
        CFG_MIN_TICKS   = 3'd2,
        CFG_MAX_TICKS   = 3'd3,
        CFG_TIMEOUT     = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic             enabled;
        logic [CFG_W-1:0] pulse_value;
        logic [CFG_W-1:0] min_ticks;
        logic [CFG_W-1:0] max_ticks;
        logic [CFG_W-1:0] quiet_timeout;
    } t_cfg;

    typedef struct packed {
        logic [PENDING_W-1:0] pending_pulses;
        logic                 pulse_rejected;
        logic                 pulse_accepted;
        logic [AMOUNT_W-1:0]  amount;
        logic                 amount_valid;
    } t_result;

endpackage

/* hdl/cpwc_core.sv */
`timescale 1ns / 1ps

module cpwc_core
    import cpwc_pkg::*;
#(
    parameter int MAX_PULSES = MAX_PULSES_DEF,
    parameter int TIME_BITS  = TIME_BITS_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  logic    i_step,
    input  logic    i_level,
    output t_result o_result
);

    localparam int CNT_W = $clog2(MAX_PULSES + 1);
    localparam int CMP_W = (TIME_BITS > CFG_W) ? TIME_BITS : CFG_W;
    localparam int MUL_W = (CNT_W + CFG_W > AMOUNT_W) ? CNT_W + CFG_W : AMOUNT_W;
    localparam int PND_W = (CNT_W > PENDING_W) ? CNT_W : PENDING_W;
    localparam logic [TIME_BITS-1:0] TIME_MAX  = {TIME_BITS{1'b1}};
    localparam logic [CNT_W-1:0]     COUNT_MAX = CNT_W'(MAX_PULSES);

    logic                 r_prev, n_prev;
    logic                 r_low_seen, n_low_seen;
    logic [TIME_BITS-1:0] r_low_width, n_low_width;
    logic [CNT_W-1:0]     r_count, n_count;
    logic [TIME_BITS-1:0] r_quiet, n_quiet;

    logic [CMP_W-1:0]     width_ext;
    logic [CMP_W-1:0]     quiet_ext;
    logic [TIME_BITS-1:0] quiet_upd;
    logic                 in_window;
    logic                 accepted;
    logic                 rejected;
    logic                 commit;
    logic [CNT_W-1:0]     count_upd;
    logic [MUL_W-1:0]     product;
    logic [PND_W-1:0]     pending_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev      <= 1'b1;
            r_low_seen  <= 1'b0;
            r_low_width <= '0;
            r_count     <= '0;
            r_quiet     <= '0;
        end else begin
            r_prev      <= n_prev;
            r_low_seen  <= n_low_seen;
            r_low_width <= n_low_width;
            r_count     <= n_count;
            r_quiet     <= n_quiet;
        end
    end

    assign width_ext = CMP_W'(r_low_width);
    assign in_window = (width_ext >= CMP_W'(i_cfg.min_ticks))
                    && (width_ext <= CMP_W'(i_cfg.max_ticks));
    // A rising edge only closes a pulse whose falling edge was seen.
    assign accepted  = i_level && !r_prev && r_low_seen && in_window;
    assign rejected  = i_level && !r_prev && r_low_seen && !in_window;
    assign count_upd = (accepted && r_count != COUNT_MAX) ? r_count + 1'b1 : r_count;
    assign quiet_upd = accepted ? '0
                     : (r_quiet != TIME_MAX) ? r_quiet + 1'b1 : r_quiet;
    assign quiet_ext = CMP_W'(quiet_upd);
    assign commit    = (count_upd != '0) && (quiet_ext >= CMP_W'(i_cfg.quiet_timeout));
    assign product   = MUL_W'(count_upd) * MUL_W'(i_cfg.pulse_value);

    always_comb begin
        n_prev      = r_prev;
        n_low_seen  = r_low_seen;
        n_low_width = r_low_width;
        n_count     = r_count;
        n_quiet     = r_quiet;
        pending_ext = '0;
        o_result    = '0;
        if (!i_cfg.enabled) begin
            n_prev      = 1'b1;
            n_low_seen  = 1'b0;
            n_low_width = '0;
            n_count     = '0;
            n_quiet     = '0;
        end else begin
            if (i_step) begin
                if (!i_level) begin
                    if (r_prev) begin
                        n_low_seen  = 1'b1;
                        n_low_width = TIME_BITS'(1);
                    end else if (r_low_seen && r_low_width != TIME_MAX) begin
                        n_low_width = r_low_width + 1'b1;
                    end
                end else if (!r_prev && r_low_seen) begin
                    n_low_seen  = 1'b0;
                    n_low_width = '0;
                end
                n_prev = i_level;
            end
            n_quiet = quiet_upd;
            n_count = commit ? '0 : count_upd;
            pending_ext = PND_W'(n_count);
            o_result.amount_valid   = commit;
            o_result.amount         = commit ? product[AMOUNT_W-1:0] : '0;
            o_result.pulse_accepted = accepted;
            o_result.pulse_rejected = rejected;
            o_result.pending_pulses = pending_ext[PENDING_W-1:0];
            if (!i_step) begin
                n_prev      = r_prev;
                n_low_seen  = r_low_seen;
                n_low_width = r_low_width;
                n_count     = r_count;
                n_quiet     = r_quiet;
            end
        end
    end

endmodule

/* hdl/coin_pulse_width_counter.sv */
`timescale 1ns / 1ps

// Coin and bill acceptor pulse counter. Each input beat is one millisecond
// sample of the active-low pulse line; every beat yields exactly one result
// beat. Low pulses whose width falls inside the min/max window are counted,
// and once the line has been quiet for the timeout after the last good pulse
// the amount (count times pulse value) is reported and the count is cleared.
// One beat is taken every clock cycle while the skid stage is empty: the state
// update, window check and the single count-by-value multiply sit between the
// state registers and the output register, and a skid stage keeps the input
// side open for one beat while the output is stalled. Clearing the enable
// register clears all state; while disabled every result beat is all zeros.

module coin_pulse_width_counter
    import cpwc_pkg::*;
#(
    parameter int MAX_PULSES = MAX_PULSES_DEF,
    parameter int TIME_BITS  = TIME_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_W-1:0]       i_cfg_data,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // bit 0: line_level
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // bits from 0: amount_valid, amount[23:0], pulse_accepted, pulse_rejected,
    // pending_pulses[7:0]
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    t_cfg    r_cfg;
    t_result step_result;
    t_result r_out, n_out;
    t_result r_skid, n_skid;
    logic    r_out_valid, n_out_valid;
    logic    r_skid_valid, n_skid_valid;
    logic    in_acc;
    logic    out_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enabled       <= 1'b0;
            r_cfg.pulse_value   <= PULSE_VALUE_RST;
            r_cfg.min_ticks     <= MIN_TICKS_RST;
            r_cfg.max_ticks     <= MAX_TICKS_RST;
            r_cfg.quiet_timeout <= TIMEOUT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ENABLED:     r_cfg.enabled       <= i_cfg_data[0];
                CFG_PULSE_VALUE: r_cfg.pulse_value   <= i_cfg_data;
                CFG_MIN_TICKS:   r_cfg.min_ticks     <= i_cfg_data;
                CFG_MAX_TICKS:   r_cfg.max_ticks     <= i_cfg_data;
                CFG_TIMEOUT:     r_cfg.quiet_timeout <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign s_axis_tready = !r_skid_valid;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_take      = m_axis_tvalid && m_axis_tready;

    cpwc_core #(
        .MAX_PULSES (MAX_PULSES),
        .TIME_BITS  (TIME_BITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_step   (in_acc),
        .i_level  (s_axis_tdata[0]),
        .o_result (step_result)
    );

    always_comb begin
        n_out        = r_out;
        n_out_valid  = r_out_valid;
        n_skid       = r_skid;
        n_skid_valid = r_skid_valid;
        if (out_take || !r_out_valid) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_out_valid  = 1'b1;
                n_skid_valid = 1'b0;
            end else begin
                n_out       = step_result;
                n_out_valid = in_acc;
            end
        end else if (in_acc) begin
            // Output is stalled: park this beat in the skid stage.
            n_skid       = step_result;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(OUT_TDATA_W - $bits(t_result))'(0), r_out};

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid stage holds a beat while the output register is empty");

    a_commit_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.amount_valid) |-> (r_out.pending_pulses == '0))
        else $error("committed beat still reports pending pulses");

    a_accept_xor_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.pulse_accepted && r_out.pulse_rejected))
        else $error("pulse both accepted and rejected");

    a_disabled_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !r_cfg.enabled && (out_take || !r_out_valid) && !r_skid_valid)
        |=> (r_out == '0))
        else $error("disabled block produced a nonzero result");

endmodule
